>>> design/mgs_pkg.sv
// Package for the median then Gaussian smoother: constants, weight table and cell control type.
`default_nettype none
package mgs_pkg;
    localparam int MEDIAN_TAPS_DEF = 7;
    localparam int SMOOTH_TAPS     = 32;
    localparam int SAMPLE_W        = 32;
    localparam int WEIGHT_W        = 13;

    localparam logic [WEIGHT_W-1:0] GAUSS_Q16 [SMOOTH_TAPS] = '{
        13'd62,   13'd81,   13'd106,  13'd137,  13'd176,  13'd224,  13'd283,  13'd353,
        13'd437,  13'd536,  13'd651,  13'd784,  13'd936,  13'd1107, 13'd1297, 13'd1506,
        13'd1734, 13'd1978, 13'd2235, 13'd2503, 13'd2779, 13'd3056, 13'd3331, 13'd3598,
        13'd3852, 13'd4086, 13'd4295, 13'd4473, 13'd4618, 13'd4724, 13'd4788, 13'd4810
    };

    typedef struct packed {
        logic fill;
        logic move;
    } t_cell_ctl;
endpackage
`default_nettype wire

>>> design/mgs_med_cell.sv
// One cell of the median chain: holds a sample and compares it with the broadcast candidate.
`default_nettype none
module mgs_med_cell
    import mgs_pkg::*;
(
    input  wire                        i_clk,
    input  t_cell_ctl                  i_ctl,
    input  wire signed [SAMPLE_W-1:0]  i_fill,
    input  wire signed [SAMPLE_W-1:0]  i_din,
    input  wire signed [SAMPLE_W-1:0]  i_cand,
    output logic signed [SAMPLE_W-1:0] o_val,
    output logic                       o_less,
    output logic                       o_equal
);
    logic signed [SAMPLE_W-1:0] r_val;

    always_ff @(posedge i_clk) begin
        if (i_ctl.fill) begin
            r_val <= i_fill;
        end else if (i_ctl.move) begin
            r_val <= i_din;
        end
    end

    assign o_val   = r_val;
    assign o_less  = (r_val < i_cand);
    assign o_equal = (r_val == i_cand);
endmodule
`default_nettype wire

>>> design/mgs_tap_cell.sv
// One cell of the smoothing chain: holds one median and passes it on.
`default_nettype none
module mgs_tap_cell
    import mgs_pkg::*;
(
    input  wire                        i_clk,
    input  t_cell_ctl                  i_ctl,
    input  wire signed [SAMPLE_W-1:0]  i_fill,
    input  wire signed [SAMPLE_W-1:0]  i_din,
    output logic signed [SAMPLE_W-1:0] o_val
);
    logic signed [SAMPLE_W-1:0] r_val;

    always_ff @(posedge i_clk) begin
        if (i_ctl.fill) begin
            r_val <= i_fill;
        end else if (i_ctl.move) begin
            r_val <= i_din;
        end
    end

    assign o_val = r_val;
endmodule
`default_nettype wire

>>> design/median_then_gaussian_smoother.sv
// Top level of the median then Gaussian smoother.
//
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+--------------------------
//  input   | in        | i_valid / o_stall    | i_sample   (32b signed)
//  output  | out       | o_valid / i_stall    | o_smoothed (32b signed)
//
// After its transfer, a sample passes through the median search as the median
// chain rotates once, one push step, the single multiply-accumulate as the
// smoothing chain rotates once, one drain step and one output step, after
// which its result is offered. A new sample is taken only once the block is
// back in idle after the output step; o_stall stays high until then.
// Reset (synchronous, active low) clears the control state only; the cells
// need no reset because the first sample fills both chains. A stall on the
// output holds the finished result; the block waits before overwriting it.
`default_nettype none
module median_then_gaussian_smoother
    import mgs_pkg::*;
#(
    parameter int MEDIAN_TAPS = MEDIAN_TAPS_DEF
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_valid,
    output logic                       o_stall,
    input  wire signed [SAMPLE_W-1:0]  i_sample,
    output logic                       o_valid,
    input  wire                        i_stall,
    output logic signed [SAMPLE_W-1:0] o_smoothed
);
    localparam int MCW   = (MEDIAN_TAPS > 1) ? $clog2(MEDIAN_TAPS) : 1;
    localparam int CNTW  = $clog2(MEDIAN_TAPS + 1);
    localparam int SCW   = $clog2(SMOOTH_TAPS);
    localparam int PROD_W = SAMPLE_W + WEIGHT_W + 1;
    localparam int ACC_W  = PROD_W + SCW;
    localparam logic [CNTW-1:0] MID = CNTW'(MEDIAN_TAPS / 2);
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(64'sd2147483647);
    localparam logic signed [ACC_W-1:0] SAT_LO = -ACC_W'(64'sd2147483648);

    typedef enum logic [2:0] {S_IDLE, S_MED, S_PUSH, S_MAC, S_DRAIN, S_OUT} t_state;

    t_state                     r_state;
    logic [MCW-1:0]             r_med_cnt;
    logic [SCW-1:0]             r_mac_cnt;
    logic                       r_primed;
    logic                       r_prod_v;
    logic signed [SAMPLE_W-1:0] r_med;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [SAMPLE_W-1:0] r_out;
    logic                       r_ovalid;

    t_cell_ctl                  w_med_ctl, w_tap_ctl;
    logic signed [SAMPLE_W-1:0] w_med_val [MEDIAN_TAPS];
    logic signed [SAMPLE_W-1:0] w_tap_val [SMOOTH_TAPS];
    logic [MEDIAN_TAPS-1:0]     w_less, w_equal;
    logic signed [SAMPLE_W-1:0] w_med_top, w_tap_top;
    logic [CNTW-1:0]            n_less, n_le;
    logic                       w_accept, w_is_med;
    logic signed [ACC_W-1:0]    w_round;
    logic signed [SAMPLE_W-1:0] n_out;

    assign w_accept = i_valid && !o_stall;
    assign o_stall  = (r_state != S_IDLE);
    assign o_valid  = r_ovalid;
    assign o_smoothed = r_out;

    // Median chain: shifts the new sample in at the top, then rotates once so
    // that every entry passes cell zero as the candidate.
    always_comb begin
        w_med_ctl.fill = w_accept && !r_primed;
        w_med_ctl.move = w_accept || (r_state == S_MED);
        w_med_top      = (r_state == S_MED) ? w_med_val[0] : i_sample;
    end

    // Smoothing chain: the median enters at the top, the oldest sits in cell
    // zero, and one rotation walks the entries oldest to newest.
    always_comb begin
        w_tap_ctl.fill = (r_state == S_PUSH) && !r_primed;
        w_tap_ctl.move = (r_state == S_PUSH) || (r_state == S_MAC);
        w_tap_top      = (r_state == S_MAC) ? w_tap_val[0] : r_med;
    end

    genvar g;
    generate
        for (g = 0; g < MEDIAN_TAPS; g++) begin : g_med
            mgs_med_cell u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_med_ctl),
                .i_fill  (i_sample),
                .i_din   ((g == MEDIAN_TAPS - 1) ? w_med_top : w_med_val[(g + 1) % MEDIAN_TAPS]),
                .i_cand  (w_med_val[0]),
                .o_val   (w_med_val[g]),
                .o_less  (w_less[g]),
                .o_equal (w_equal[g])
            );
        end
        for (g = 0; g < SMOOTH_TAPS; g++) begin : g_tap
            mgs_tap_cell u_cell (
                .i_clk  (i_clk),
                .i_ctl  (w_tap_ctl),
                .i_fill (r_med),
                .i_din  ((g == SMOOTH_TAPS - 1) ? w_tap_top : w_tap_val[(g + 1) % SMOOTH_TAPS]),
                .o_val  (w_tap_val[g])
            );
        end
    endgenerate

    // The candidate is the median when fewer than half+1 entries lie below it
    // and more than half lie at or below it; ties need no ordering.
    always_comb begin
        n_less = '0;
        n_le   = '0;
        for (int i = 0; i < MEDIAN_TAPS; i++) begin
            n_less = n_less + CNTW'(w_less[i]);
            n_le   = n_le + CNTW'(w_less[i] | w_equal[i]);
        end
        w_is_med = (n_less <= MID) && (n_le > MID);
    end

    // Round half up, floor by the arithmetic shift, then saturate.
    always_comb begin
        w_round = (r_acc + ACC_W'(32768)) >>> 16;
        if (w_round > SAT_HI) begin
            n_out = SAT_HI[SAMPLE_W-1:0];
        end else if (w_round < SAT_LO) begin
            n_out = SAT_LO[SAMPLE_W-1:0];
        end else begin
            n_out = w_round[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_tap_val[0] * $signed({1'b0, GAUSS_Q16[r_mac_cnt]});
        if (r_state == S_MED && w_is_med) begin
            r_med <= w_med_val[0];
        end
        if (r_state == S_PUSH) begin
            r_acc <= '0;
        end else if (r_prod_v) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
        if (r_state == S_OUT && (!r_ovalid || !i_stall)) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_med_cnt <= '0;
            r_mac_cnt <= '0;
            r_primed  <= 1'b0;
            r_prod_v  <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            r_prod_v <= (r_state == S_MAC);
            // A new result replaces the old one in the cycle it leaves.
            if (r_state == S_OUT && (!r_ovalid || !i_stall)) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_med_cnt <= '0;
                        r_state   <= S_MED;
                    end
                end
                S_MED: begin
                    if (r_med_cnt == MCW'(MEDIAN_TAPS - 1)) begin
                        r_state <= S_PUSH;
                    end else begin
                        r_med_cnt <= r_med_cnt + 1'b1;
                    end
                end
                S_PUSH: begin
                    r_primed  <= 1'b1;
                    r_mac_cnt <= '0;
                    r_state   <= S_MAC;
                end
                S_MAC: begin
                    r_mac_cnt <= r_mac_cnt + 1'b1;
                    if (r_mac_cnt == SCW'(SMOOTH_TAPS - 1)) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ovalid || !i_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_out_from_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state == S_OUT))
        else $error("result offered without passing the output state");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_stall)
        else $error("block not busy after an input transfer");

    a_med_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MED) |-> (r_med_cnt <= MCW'(MEDIAN_TAPS - 1)))
        else $error("median step count out of range");
endmodule
`default_nettype wire
